FILE: design/sccr_pkg.sv
// Shared types, constants and command codes for the sector cache replacement unit.
package sccr_pkg;

	localparam int unsigned DefaultEntries = 64;
	localparam int unsigned SectorWidth = 32;
	localparam int unsigned EntryWidth = 6;
	localparam logic [SectorWidth-1:0] EmptyTag = '1;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_FLUSH = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]             cmd;
		logic [SectorWidth-1:0] sector;
	} in_item_t;

	typedef struct packed {
		logic [EntryWidth-1:0]  entry;
		logic                   hit;
		logic                   fill;
		logic                   writeback_valid;
		logic [SectorWidth-1:0] writeback_sector;
		logic                   last;
	} out_item_t;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		OP_IDLE   = 4'd0,
		OP_START  = 4'd1,
		OP_SCAN   = 4'd2,
		OP_FREE   = 4'd3,
		OP_SWEEP  = 4'd4,
		OP_READ   = 4'd5,
		OP_UPDATE = 4'd6,
		OP_FSCAN  = 4'd7,
		OP_FLOAD  = 4'd8,
		OP_FLAST  = 4'd9,
		OP_FEMPTY = 4'd10
	} op_t;

	typedef struct packed {
		op_t  op;
		logic is_write;
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic hit_found;
		logic free_found;
		logic victim_found;
		logic dirty_found;
		logic flush_done;
		logic reset_done;
	} ctl_stat_t;

endpackage

FILE: design/sccr_datapath.sv
// Tag memory, status bits, clock hand and the per-entry scan engine.
module sccr_datapath #(
	parameter int unsigned ENTRIES = sccr_pkg::DefaultEntries
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sccr_pkg::ctl_cmd_t             ctl,
	input  logic [sccr_pkg::SectorWidth-1:0] sector,
	output sccr_pkg::ctl_stat_t            stat,
	output sccr_pkg::out_item_t            result
);
	localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

	logic [sccr_pkg::SectorWidth-1:0] tag_mem [ENTRIES];
	logic [ENTRIES-1:0] used_q, dirty_q, ref_q;
	logic [IdxW-1:0] hand_q, idx_q, slot_q, free_q, cmp_idx_q, clr_q;
	logic            clr_busy_q;
	logic            free_ok_q, hit_q, cmp_v_q;
	logic [sccr_pkg::SectorWidth-1:0] rd_q;

	function automatic logic [IdxW-1:0] nxt(input logic [IdxW-1:0] i);
		return (i == LastIdx) ? '0 : i + 1'b1;
	endfunction

	// tag memory: one registered read, one write per cycle
	logic                             we;
	logic [IdxW-1:0]                  wa;
	logic [sccr_pkg::SectorWidth-1:0] wd;
	logic                             re;
	logic [IdxW-1:0]                  ra;

	always_comb begin
		we = 1'b0;
		wa = slot_q;
		wd = sector;
		re = 1'b0;
		ra = idx_q;
		if (clr_busy_q) begin
			we = 1'b1;
			wa = clr_q;
			wd = sccr_pkg::EmptyTag;
		end else begin
			case (ctl.op)
				sccr_pkg::OP_SCAN: re = 1'b1;
				sccr_pkg::OP_FSCAN: re = dirty_q[idx_q];
				sccr_pkg::OP_READ: begin
					re = 1'b1;
					ra = slot_q;
				end
				sccr_pkg::OP_UPDATE: we = !hit_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we) tag_mem[wa] <= wd;
		if (re) rd_q <= tag_mem[ra];
	end

	always_comb begin
		stat = '0;
		stat.reset_done = !clr_busy_q;
		stat.hit_found = cmp_v_q && rd_q == sector;
		stat.scan_done = cmp_v_q && cmp_idx_q == LastIdx;
		stat.free_found = free_ok_q;
		stat.victim_found = !ref_q[hand_q];
		stat.dirty_found = dirty_q[idx_q];
		stat.flush_done = idx_q == LastIdx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			dirty_q <= '0;
			ref_q <= '0;
			hand_q <= '0;
			idx_q <= '0;
			slot_q <= '0;
			free_q <= '0;
			free_ok_q <= 1'b0;
			hit_q <= 1'b0;
			clr_q <= '0;
			clr_busy_q <= 1'b1;
			cmp_idx_q <= '0;
			cmp_v_q <= 1'b0;
			result <= '0;
		end else begin
			cmp_v_q <= ctl.op == sccr_pkg::OP_SCAN;
			if (clr_busy_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == LastIdx) clr_busy_q <= 1'b0;
			end
			case (ctl.op)
				sccr_pkg::OP_START: begin
					idx_q <= '0;
					free_ok_q <= 1'b0;
					hit_q <= 1'b0;
				end
				sccr_pkg::OP_SCAN: begin
					// read address advances; the compare works on the previous index through the registered read
					cmp_idx_q <= idx_q;
					if (idx_q != LastIdx) idx_q <= idx_q + 1'b1;
					if (!used_q[idx_q] && !free_ok_q) begin
						free_ok_q <= 1'b1;
						free_q <= idx_q;
					end
					if (cmp_v_q && rd_q == sector) begin
						hit_q <= 1'b1;
						slot_q <= cmp_idx_q;
					end
				end
				sccr_pkg::OP_FREE: begin
					slot_q <= free_q;
					hand_q <= nxt(free_q);
				end
				sccr_pkg::OP_SWEEP: begin
					// one sweep step: clear and skip a referenced entry, or take the victim
					hand_q <= nxt(hand_q);
					if (ref_q[hand_q]) ref_q[hand_q] <= 1'b0;
					else slot_q <= hand_q;
				end
				sccr_pkg::OP_UPDATE: begin
					result.entry <= sccr_pkg::EntryWidth'(slot_q);
					result.hit <= hit_q;
					result.fill <= !hit_q;
					result.last <= 1'b1;
					result.writeback_valid <= !hit_q && dirty_q[slot_q];
					result.writeback_sector <= (!hit_q && dirty_q[slot_q]) ? rd_q : '0;
					if (!hit_q) used_q[slot_q] <= 1'b1;
					ref_q[slot_q] <= 1'b1;
					dirty_q[slot_q] <= ctl.is_write || (hit_q && dirty_q[slot_q]);
				end
				sccr_pkg::OP_FSCAN: begin
					// walk entries; a dirty one has its tag read and its mark dropped
					if (idx_q != LastIdx) idx_q <= idx_q + 1'b1;
					if (dirty_q[idx_q]) begin
						slot_q <= idx_q;
						dirty_q[idx_q] <= 1'b0;
					end
				end
				sccr_pkg::OP_FLOAD: begin
					result <= '{entry: sccr_pkg::EntryWidth'(slot_q), hit: 1'b0, fill: 1'b0,
						writeback_valid: 1'b1, writeback_sector: rd_q, last: 1'b0};
				end
				sccr_pkg::OP_FLAST: result.last <= 1'b1;
				sccr_pkg::OP_FEMPTY: begin
					result <= '{entry: '0, hit: 1'b0, fill: 1'b0, writeback_valid: 1'b0,
						writeback_sector: '0, last: 1'b1};
				end
				default: ;
			endcase
		end
	end
endmodule

FILE: design/sccr_ctrl.sv
// Controller state machine sequencing lookup, sweep, update and flush.
module sccr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          in_cmd,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  sccr_pkg::ctl_stat_t stat,
	output sccr_pkg::ctl_cmd_t  ctl
);
	typedef enum logic [3:0] {
		S_IDLE, S_START, S_SCAN, S_FREE, S_SWEEP, S_RD, S_UPD, S_OUT,
		S_FSTART, S_FSCAN, S_FLOAD, S_FOUT, S_FFIN, S_FEMPTY
	} state_t;

	state_t state_q;
	logic   wr_q, flush_any_q, fend_q;

	assign in_ready = state_q == S_IDLE && stat.reset_done;

	always_comb begin
		ctl = '0;
		ctl.is_write = wr_q;
		case (state_q)
			S_START, S_FSTART: ctl.op = sccr_pkg::OP_START;
			S_SCAN: ctl.op = sccr_pkg::OP_SCAN;
			S_FREE: ctl.op = sccr_pkg::OP_FREE;
			S_SWEEP: ctl.op = sccr_pkg::OP_SWEEP;
			S_RD: ctl.op = sccr_pkg::OP_READ;
			S_UPD: ctl.op = sccr_pkg::OP_UPDATE;
			S_FSCAN: ctl.op = sccr_pkg::OP_FSCAN;
			S_FLOAD: ctl.op = sccr_pkg::OP_FLOAD;
			S_FFIN: ctl.op = sccr_pkg::OP_FLAST;
			S_FEMPTY: ctl.op = sccr_pkg::OP_FEMPTY;
			default: ctl.op = sccr_pkg::OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wr_q <= 1'b0;
			out_valid <= 1'b0;
			flush_any_q <= 1'b0;
			fend_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					wr_q <= in_cmd == sccr_pkg::CMD_WRITE;
					if (in_cmd == sccr_pkg::CMD_FLUSH) state_q <= S_FSTART;
					else if (in_cmd != sccr_pkg::CMD_NONE) state_q <= S_START;
				end
				S_START: state_q <= S_SCAN;
				S_SCAN: begin
					if (stat.hit_found) state_q <= S_RD;
					else if (stat.scan_done) state_q <= stat.free_found ? S_FREE : S_SWEEP;
				end
				S_FREE: state_q <= S_RD;
				S_SWEEP: if (stat.victim_found) state_q <= S_RD;
				S_RD: state_q <= S_UPD;
				S_UPD: begin
					out_valid <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: if (out_ready) begin
					out_valid <= 1'b0;
					state_q <= S_IDLE;
				end
				S_FSTART: begin
					flush_any_q <= 1'b0;
					state_q <= S_FSCAN;
				end
				S_FSCAN: begin
					// hold the previous dirty entry until the next one shows it is not the last
					if (stat.dirty_found) begin
						fend_q <= stat.flush_done;
						if (flush_any_q) begin
							out_valid <= 1'b1;
							state_q <= S_FOUT;
						end else begin
							state_q <= S_FLOAD;
						end
					end else if (stat.flush_done) begin
						state_q <= flush_any_q ? S_FFIN : S_FEMPTY;
					end
				end
				S_FLOAD: begin
					flush_any_q <= 1'b1;
					state_q <= fend_q ? S_FFIN : S_FSCAN;
				end
				S_FOUT: if (out_ready) begin
					out_valid <= 1'b0;
					state_q <= S_FLOAD;
				end
				S_FFIN, S_FEMPTY: begin
					out_valid <= 1'b1;
					state_q <= S_OUT;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: design/sector_cache_clock_replacement_unit.sv
// Top level of the sector cache clock replacement unit.
// Items are handled one at a time. An access scans the tags serially through the registered
// read port of the tag memory: a hit ends the scan at that entry; a miss takes a never-used
// entry if there is one, else a clock sweep picks a victim when every entry is in use. A
// flush walks every entry one per cycle while no dirty entry holds it, adds a load step and
// an output handshake per dirty entry, and ends with a closing step. The next transaction
// can be accepted from the cycle after the last result is taken. After reset the tag memory
// is cleared to all ones, entry by entry, and no transaction is accepted until it is done.
module sector_cache_clock_replacement_unit #(
	parameter int unsigned ENTRIES = sccr_pkg::DefaultEntries
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sccr_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output sccr_pkg::out_item_t out_data
);
	sccr_pkg::ctl_cmd_t  ctl;
	sccr_pkg::ctl_stat_t stat;
	logic [sccr_pkg::SectorWidth-1:0] sector_q;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) sector_q <= in_data.sector;
	end

	sccr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_cmd(in_data.cmd),
		.in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
		.stat(stat), .ctl(ctl)
	);

	sccr_datapath #(.ENTRIES(ENTRIES)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sector(sector_q),
		.stat(stat), .result(out_data)
	);
endmodule
